[rtl/core/grid_neighbour_count_threshold_unit_macros.svh]
// Assertion macros shared by the grid neighbour count threshold unit
`ifndef GRID_NEIGHBOUR_COUNT_THRESHOLD_UNIT_MACROS_SVH
`define GRID_NEIGHBOUR_COUNT_THRESHOLD_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define GNCT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define GNCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gnct_pkg.sv]
// Types, constants and helper functions of the grid neighbour count threshold unit
`timescale 1ns / 1ps

package gnct_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;

   // column index, row position (runs to MAX_ROWS + 1 while draining)
   localparam int COL_W     = $clog2(MAX_COLUMNS);
   localparam int ROW_IDX_W = $clog2(MAX_ROWS);
   localparam int ROW_W     = $clog2(MAX_ROWS + 2);

   localparam int CSR_W       = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int LIMIT_W     = 4;
   localparam int COUNT_W     = 4;
   localparam int TOTAL_W     = 17;
   localparam int OUT_COL_W   = 8;
   localparam int OUT_ROW_W   = 8;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [CSR_W-1:0]   COLUMNS_RESET = CSR_W'(256);
   localparam logic [CSR_W-1:0]   ROWS_RESET    = CSR_W'(256);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(4);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_COLUMNS    = 2'd0,
      CSR_GRID_ROWS       = 2'd1,
      CSR_NEIGHBOUR_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic occupied;
      logic pad;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] centre_col;
      logic [OUT_ROW_W-1:0] centre_row;
      logic [COUNT_W-1:0]   neighbour_count;
      logic                 marked;
      logic [TOTAL_W-1:0]   marked_total;
      logic                 frame_last;
   } rsp_payload_type;

   // line store entry: one pixel of each of the two previous rows
   typedef struct packed {
      logic middle;
      logic upper;
   } line_pair_type;

   function automatic logic [COUNT_W-1:0] count_ones9(input logic [8:0] m);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < 9; i++) begin
         n = n + COUNT_W'(m[i]);
      end
      return n;
   endfunction

   // last column index in use: zero counts as one column, oversize as MAX_COLUMNS
   function automatic logic [COL_W-1:0] clamp_last_col(input logic [CSR_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_COLUMNS) begin
         r = COL_W'(MAX_COLUMNS - 1);
      end else begin
         r = COL_W'(v - CSR_W'(1));
      end
      return r;
   endfunction

   function automatic logic [ROW_IDX_W-1:0] clamp_last_row(input logic [CSR_W-1:0] v);
      logic [ROW_IDX_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_ROWS) begin
         r = ROW_IDX_W'(MAX_ROWS - 1);
      end else begin
         r = ROW_IDX_W'(v - CSR_W'(1));
      end
      return r;
   endfunction

endpackage

[rtl/core/gnct_if.sv]
// Request and response channel interfaces of the grid neighbour count threshold unit
`timescale 1ns / 1ps

interface gnct_req_if import gnct_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface gnct_rsp_if import gnct_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/grid_neighbour_count_threshold_unit.sv]
// Top level of the grid neighbour count threshold unit
`timescale 1ns / 1ps
`include "grid_neighbour_count_threshold_unit_macros.svh"

// 3x3 neighbour count over a binary raster streamed one pixel per request in
// row-major order. For each centre pixel the unit reports how many of its eight
// neighbours are occupied (pixels outside the grid count as empty), marks an
// occupied centre whose count is below neighbour_limit, and keeps a saturating
// running total of marks for the frame. The unit accepts one request every
// clock cycle unless the sink holds a response; each result is registered and
// appears in the cycle after the request that completes it. The result for pixel p
// comes with request p + grid_columns + 1, so after the last pixel the host
// sends grid_columns + 1 pad requests to drain the window. The line store is a
// single-port-write, single-port-read memory whose entry for the next column is
// fetched ahead through its registered read, which is what allows a new pixel
// every cycle. A response held by the sink stalls the request side for as long
// as it is held, whether or not the next request would produce a result.
// Any write to grid_columns, grid_rows or neighbour_limit, and the frame_last
// result, restart the frame; the line store needs no clearing pass because
// entries are qualified by the row position.

module grid_neighbour_count_threshold_unit import gnct_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_wr_data,
   gnct_req_if.sink               req_chan,
   gnct_rsp_if.source             rsp_chan
);

   // configuration
   logic [CSR_W-1:0]     cols_ff, cols_in;
   logic [CSR_W-1:0]     rows_ff, rows_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [COL_W-1:0]     last_col;
   logic [ROW_IDX_W-1:0] last_row;
   logic                 csr_hit;

   // position, window and total
   logic [COL_W-1:0]     col_ff, col_in, col_step;
   logic [ROW_W-1:0]     row_ff, row_in, row_step;
   logic [8:0]           window_ff, window_in, win_shift;
   logic [TOTAL_W-1:0]   total_ff, total_in, total_next;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   // per-request evaluation
   logic                 req_fire;
   logic                 pix;
   line_pair_type        line_rd, line_wr;
   logic                 mid_bit, up_bit;
   logic                 edge_have, inner_have, have;
   logic [8:0]           nmask;
   logic                 centre;
   logic [COL_W-1:0]     ccol;
   logic [ROW_W-1:0]     crow;
   logic [COUNT_W-1:0]   cnt;
   logic                 mk, last, frame_end, restart;

   assign last_col = clamp_last_col(cols_ff);
   assign last_row = clamp_last_row(rows_ff);

   assign csr_hit = csr_wr_en && ((csr_index == CSR_GRID_COLUMNS) ||
                                  (csr_index == CSR_GRID_ROWS) ||
                                  (csr_index == CSR_NEIGHBOUR_LIMIT));

   // accept whenever the response register is free or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // pad wins over occupied
   assign pix = req_chan.payload.occupied && !req_chan.payload.pad;

   // rows above row zero are empty: qualify the stored bits by the row position
   assign mid_bit = line_rd.middle && (row_ff != '0);
   assign up_bit  = line_rd.upper && (row_ff > ROW_W'(1));

   assign line_wr.middle = pix;
   assign line_wr.upper  = mid_bit;

   // window bit 3*slot + row; slot 2 is the newest column
   assign win_shift = {pix, mid_bit, up_bit, window_ff[8:3]};

   // column zero closes the last column of the row two back (old window);
   // any other column closes the column to its left (shifted window)
   assign edge_have  = (col_ff == '0) && (row_ff > ROW_W'(1));
   assign inner_have = (col_ff != '0) && (row_ff != '0);
   assign have       = edge_have || inner_have;

   always_comb begin
      if (edge_have) begin
         centre = window_ff[7];
         nmask  = window_ff & 9'h178;
         if (last_col == '0) begin
            // single column: only the pixels above and below
            nmask = nmask & 9'h1C0;
         end
         ccol = last_col;
         crow = row_ff - ROW_W'(2);
      end else begin
         centre = win_shift[4];
         nmask  = win_shift & 9'h1EF;
         if (col_ff == COL_W'(1)) begin
            // left edge: drop the wrapped column
            nmask = nmask & 9'h1F8;
         end
         ccol = col_ff - COL_W'(1);
         crow = row_ff - ROW_W'(1);
      end
   end

   assign cnt  = count_ones9(nmask);
   assign mk   = centre && (cnt < limit_ff);
   assign last = (crow == ROW_W'(last_row)) && (ccol == last_col);

   assign total_next = (mk && (total_ff != TOTAL_MAX)) ? total_ff + TOTAL_W'(1) : total_ff;

   assign frame_end = req_fire && have && last;
   assign restart   = csr_hit || frame_end;

   // advance the raster position, wrapping at the last column
   always_comb begin
      if (col_ff == last_col) begin
         col_step = '0;
         row_step = row_ff + ROW_W'(1);
      end else begin
         col_step = col_ff + COL_W'(1);
         row_step = row_ff;
      end
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      window_in = window_ff;
      total_in  = total_ff;
      if (restart) begin
         col_in    = '0;
         row_in    = '0;
         window_in = '0;
         total_in  = '0;
      end else if (req_fire) begin
         col_in    = col_step;
         row_in    = row_step;
         window_in = win_shift;
         if (have) begin
            total_in = total_next;
         end
      end
   end

   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      limit_in = limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_COLUMNS:    cols_in  = csr_wr_data;
            CSR_GRID_ROWS:       rows_in  = csr_wr_data;
            CSR_NEIGHBOUR_LIMIT: limit_in = csr_wr_data[LIMIT_W-1:0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // load a new result, or drop the held one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire && have) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.centre_col      = OUT_COL_W'(ccol);
         rsp_data_in.centre_row      = crow[OUT_ROW_W-1:0];
         rsp_data_in.neighbour_count = cnt;
         rsp_data_in.marked          = mk;
         rsp_data_in.marked_total    = total_next;
         rsp_data_in.frame_last      = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         limit_ff     <= LIMIT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         window_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         limit_ff     <= limit_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         window_ff    <= window_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // fetch the entry for the next column ahead through the registered read
   gnct_line_store u_line_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (col_ff),
      .wr_data (line_wr),
      .rd_addr (col_in),
      .rd_data (line_rd)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `GNCT_ASSERT_NEXT(a_frame_restart, clock, reset, frame_end,
      (col_ff == '0) && (row_ff == '0) && (total_ff == '0),
      "frame state not cleared after last result")
   `GNCT_ASSERT_NOW(a_col_in_range, clock, reset, 1'b1, col_ff <= last_col,
      "column position beyond last column")
   `GNCT_ASSERT_NOW(a_mark_below_limit, clock, reset, rsp_valid_ff && rsp_data_ff.marked,
      rsp_data_ff.neighbour_count < limit_ff, "marked result not below limit")
   `GNCT_ASSERT_NOW(a_count_max, clock, reset, rsp_valid_ff,
      rsp_data_ff.neighbour_count <= COUNT_W'(8), "neighbour count above eight")

endmodule

[rtl/core/gnct_line_store.sv]
// Two-row line store with registered read and write-to-read forwarding
`timescale 1ns / 1ps

module gnct_line_store import gnct_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  line_pair_type    wr_data,
   input  logic [COL_W-1:0] rd_addr,
   output line_pair_type    rd_data
);

   line_pair_type mem [MAX_COLUMNS];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // forward a same-address write (single-column grid, or a restart at column zero)
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
